// ===== hw/rtl/bmhq_pkg.sv =====
// Package for the binary max-heap queue: widths, action and status codes.
package bmhq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 2;
  localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic signed [DATA_W-1:0] prio_t;

  localparam action_t ACT_INSERT  = 2'd0;
  localparam action_t ACT_EXTRACT = 2'd1;
  localparam action_t ACT_CHANGE  = 2'd2;
  localparam action_t ACT_REMOVE  = 2'd3;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_BADIDX = 2'd3;

endpackage

// ===== hw/rtl/bmhq_if.sv =====
// Valid/ready channel interfaces for heap requests and heap results.
interface bmhq_in_if;
  import bmhq_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  logic [POS_W-1:0] position;
  prio_t   priority_req;

  modport source (output valid, action, position, priority_req, input ready);
  modport sink   (input valid, action, position, priority_req, output ready);
endinterface

interface bmhq_out_if #(
  parameter int CNT_W = bmhq_pkg::CNT_W_DEF
);
  import bmhq_pkg::*;

  logic    valid;
  logic    ready;
  prio_t   taken_value;
  prio_t   top_value;
  logic [CNT_W-1:0] entry_count;
  status_t status;

  modport source (output valid, taken_value, top_value, entry_count, status, input ready);
  modport sink   (input valid, taken_value, top_value, entry_count, status, output ready);
endinterface

// ===== hw/rtl/binary_max_heap_queue.sv =====
// Binary max-heap priority queue: one RAM, one comparator, a sift sequencer.
//
//   channel  dir  handshake             payload
//   in_ch    in   valid/ready (sink)    action, position, priority_req
//   out_ch   out  valid/ready (source)  taken_value, top_value, entry_count, status
//
// Each request walks a root-to-leaf path, a remove its ancestors first; heap RAM reads are registered.
// in_ch.ready is high only while the sequencer is idle; a finished result sits in
// the output register, so one new request may be taken while it waits.
// Synchronous active-low reset clears the count and control; the RAM holds garbage.
module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bmhq_in_if.sink    in_ch,
  bmhq_out_if.source out_ch
);
  import bmhq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_UP_ISSUE  = 4'd1;
  localparam logic [3:0] S_UP_CMP    = 4'd2;
  localparam logic [3:0] S_CHG_ISSUE = 4'd3;
  localparam logic [3:0] S_CHG_CMP   = 4'd4;
  localparam logic [3:0] S_TAKE_ISSUE= 4'd5;
  localparam logic [3:0] S_TAKE_GOT  = 4'd6;
  localparam logic [3:0] S_RM_ISSUE  = 4'd7;
  localparam logic [3:0] S_RM_MOVE   = 4'd8;
  localparam logic [3:0] S_LAST_ISSUE= 4'd9;
  localparam logic [3:0] S_LAST_GOT  = 4'd10;
  localparam logic [3:0] S_DN_ISSUE  = 4'd11;
  localparam logic [3:0] S_DN_LEFT   = 4'd12;
  localparam logic [3:0] S_DN_RIGHT  = 4'd13;
  localparam logic [3:0] S_TOP_ISSUE = 4'd14;
  localparam logic [3:0] S_TOP_GOT   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  prio_t         cur_r, cur_nxt;
  prio_t         bv_r, bv_nxt;
  logic          lw_r, lw_nxt;
  prio_t         taken_r, taken_nxt;
  status_t       status_r, status_nxt;

  logic          out_valid_r;
  prio_t         out_taken_r, out_top_r;
  logic [CW-1:0] out_cnt_r;
  status_t       out_status_r;
  logic          out_load;

  // heap RAM: one write, one registered read per cycle
  prio_t         mem [CAPACITY];
  prio_t         rdata_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  prio_t         mem_wdata;

  prio_t         cmp_a, cmp_b;
  logic          cmp_gt;

  logic [IW-1:0] par;
  logic [XW-1:0] lx, rx, cnt_x;
  logic [CW+POS_W-1:0] pos_x, cnt_px;
  logic          pos_bad;

  assign cmp_gt  = cmp_a > cmp_b;
  assign par     = (i_r - IW'(1)) >> 1;
  assign lx      = {1'b0, i_r, 1'b1};
  assign rx      = lx + XW'(1);
  assign cnt_x   = XW'(cnt_r);
  assign pos_x   = {{CW{1'b0}}, in_ch.position};
  assign cnt_px  = {{POS_W{1'b0}}, cnt_r};
  assign pos_bad = pos_x >= cnt_px;

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    bv_nxt     = bv_r;
    lw_nxt     = lw_r;
    taken_nxt  = taken_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = i_r;
    mem_wdata  = cur_r;
    mem_raddr  = i_r;
    cmp_a      = cur_r;
    cmp_b      = rdata_r;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          taken_nxt  = '0;
          status_nxt = ST_OK;
          cur_nxt    = in_ch.priority_req;
          case (in_ch.action)
            ACT_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_TOP_ISSUE;
              end else begin
                i_nxt     = IW'(cnt_r);
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_ISSUE;
              end
            end
            ACT_EXTRACT: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_TOP_ISSUE;
              end else begin
                i_nxt     = '0;
                state_nxt = S_TAKE_ISSUE;
              end
            end
            ACT_CHANGE: begin
              if (pos_bad) begin
                status_nxt = ST_BADIDX;
                state_nxt  = S_TOP_ISSUE;
              end else begin
                i_nxt     = IW'(in_ch.position);
                state_nxt = S_CHG_ISSUE;
              end
            end
            ACT_REMOVE: begin
              if (pos_bad) begin
                status_nxt = ST_BADIDX;
                state_nxt  = S_TOP_ISSUE;
              end else begin
                i_nxt     = IW'(in_ch.position);
                state_nxt = S_TAKE_ISSUE;
              end
            end
            default: state_nxt = S_TOP_ISSUE;
          endcase
        end
      end
      // sift up: hole at i, moving value in cur_r
      S_UP_ISSUE: begin
        if (i_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_TOP_ISSUE;
        end else begin
          mem_raddr = par;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          mem_wdata = rdata_r;
          i_nxt     = par;
          state_nxt = S_UP_ISSUE;
        end else begin
          state_nxt = S_TOP_ISSUE;
        end
      end
      S_CHG_ISSUE: state_nxt = S_CHG_CMP;
      S_CHG_CMP:   state_nxt = cmp_gt ? S_UP_ISSUE : S_DN_ISSUE;
      S_TAKE_ISSUE: state_nxt = S_TAKE_GOT;
      S_TAKE_GOT: begin
        taken_nxt = rdata_r;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_RM_ISSUE;
      end
      // remove: shift every ancestor down one level, root becomes the hole
      S_RM_ISSUE: begin
        if (i_r == '0) begin
          state_nxt = S_LAST_ISSUE;
        end else begin
          mem_raddr = par;
          state_nxt = S_RM_MOVE;
        end
      end
      S_RM_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        i_nxt     = par;
        state_nxt = S_RM_ISSUE;
      end
      S_LAST_ISSUE: begin
        if (cnt_r == '0) begin
          state_nxt = S_TOP_ISSUE;
        end else begin
          mem_raddr = IW'(cnt_r);
          state_nxt = S_LAST_GOT;
        end
      end
      S_LAST_GOT: begin
        cur_nxt   = rdata_r;
        i_nxt     = '0;
        state_nxt = S_DN_ISSUE;
      end
      // sift down toward the larger child, left wins ties
      S_DN_ISSUE: begin
        if (lx >= cnt_x) begin
          mem_we    = 1'b1;
          state_nxt = S_TOP_ISSUE;
        end else begin
          mem_raddr = lx[IW-1:0];
          state_nxt = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        cmp_a  = rdata_r;
        cmp_b  = cur_r;
        lw_nxt = cmp_gt;
        bv_nxt = cmp_gt ? rdata_r : cur_r;
        if (rx < cnt_x) begin
          mem_raddr = rx[IW-1:0];
          state_nxt = S_DN_RIGHT;
        end else if (cmp_gt) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_r;
          i_nxt     = lx[IW-1:0];
          state_nxt = S_DN_ISSUE;
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_TOP_ISSUE;
        end
      end
      S_DN_RIGHT: begin
        cmp_a  = rdata_r;
        cmp_b  = bv_r;
        mem_we = 1'b1;
        if (cmp_gt) begin
          mem_wdata = rdata_r;
          i_nxt     = rx[IW-1:0];
          state_nxt = S_DN_ISSUE;
        end else if (lw_r) begin
          mem_wdata = bv_r;
          i_nxt     = lx[IW-1:0];
          state_nxt = S_DN_ISSUE;
        end else begin
          state_nxt = S_TOP_ISSUE;
        end
      end
      S_TOP_ISSUE: begin
        mem_raddr = '0;
        state_nxt = S_TOP_GOT;
      end
      S_TOP_GOT: begin
        mem_raddr = '0;
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    cur_r    <= cur_nxt;
    bv_r     <= bv_nxt;
    lw_r     <= lw_nxt;
    taken_r  <= taken_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_taken_r  <= taken_r;
      out_top_r    <= (cnt_r != '0) ? rdata_r : '0;
      out_cnt_r    <= cnt_r;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.taken_value = out_taken_r;
  assign out_ch.top_value   = out_top_r;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.status      = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("heap count above capacity");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_cnt_r == CW'(CAPACITY))
    else $error("full status with room left");

  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |-> out_cnt_r == '0 && out_taken_r == '0)
    else $error("empty status with entries or a taken value");

  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TOP_GOT && status_r != ST_OK |-> $stable(cnt_r))
    else $error("error request changed the count");

endmodule

// ===== verif/binary_max_heap_queue_tb.sv =====
// Testbench for binary_max_heap_queue: directed table plus random requests, checked by a heap mirror.
`timescale 1ns / 100ps

module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int HEAP_SLOTS   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_ITEMS   = 100;    // tail of the random part with no idling
  localparam int HOLD_AT_ITEM = 150;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;     // margin after the last result; the worst request is a deep remove
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef logic [CNT_W_DEF-1:0] count_t;

  typedef struct packed {
    prio_t   taken;
    prio_t   top;
    count_t  count;
    status_t status;
  } heap_result_t;

  typedef struct packed {
    action_t          act;
    logic [POS_W-1:0] pos;
    prio_t            prio;
    logic             fixed;
    heap_result_t     want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  binary_max_heap_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mirror of the heap, updated at each accepted request
  prio_t       heap_mirror [HEAP_SLOTS];
  int unsigned heap_fill;

  heap_result_t pending_results [$];

  bit idle_enabled;
  bit hold_request;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned op_count [4];
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned badidx_hits;

  stim_row_t directed_rows [25] = '{
    '{ACT_EXTRACT, 4'd0,  32'sd0,          1'b1, '{32'sd0, 32'sd0, 5'd0, ST_EMPTY}},
    '{ACT_CHANGE,  4'd0,  32'sd42,         1'b1, '{32'sd0, 32'sd0, 5'd0, ST_BADIDX}},
    '{ACT_REMOVE,  4'd15, 32'sd0,          1'b1, '{32'sd0, 32'sd0, 5'd0, ST_BADIDX}},
    '{ACT_INSERT,  4'd0,  32'sh8000_0000,  1'b1,
      '{32'sd0, 32'sh8000_0000, 5'd1, ST_OK}},
    '{ACT_INSERT,  4'd0,  32'sh7fff_ffff,  1'b1,
      '{32'sd0, 32'sh7fff_ffff, 5'd2, ST_OK}},
    '{ACT_INSERT,  4'd0,  32'sd0,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  -32'sd1,         1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd5,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd5,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd5,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd7,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd7,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  -32'sd100,       1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd1000,       1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sh7fff_fffe,  1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sh8000_0001,  1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sd5,          1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'sh5555_5555,  1'b0, '0},
    '{ACT_INSERT,  4'd0,  32'shaaaa_aaaa,  1'b0, '0},
    '{ACT_INSERT,  4'd15, 32'sd1,          1'b1,
      '{32'sd0, 32'sh7fff_ffff, 5'd16, ST_FULL}},
    '{ACT_CHANGE,  4'd15, 32'sh7fff_ffff,  1'b0, '0},
    '{ACT_CHANGE,  4'd0,  32'sh8000_0000,  1'b0, '0},
    '{ACT_REMOVE,  4'd9,  32'sd0,          1'b0, '0},
    '{ACT_REMOVE,  4'd0,  32'sd0,          1'b0, '0},
    '{ACT_CHANGE,  4'd15, 32'sd3,          1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    prio_t t;
    t = heap_mirror[a];
    heap_mirror[a] = heap_mirror[b];
    heap_mirror[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned slot);
    int unsigned parent;
    while (slot > 0) begin
      parent = (slot - 1) / 2;
      if (!(heap_mirror[slot] > heap_mirror[parent])) break;
      swap_slots(slot, parent);
      slot = parent;
    end
  endfunction

  // strict compares, left child checked first, so a tie goes left
  function automatic void sink_down(int unsigned slot);
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    forever begin
      best = slot;
      lc   = 2 * slot + 1;
      rc   = 2 * slot + 2;
      if (lc < heap_fill && heap_mirror[lc] > heap_mirror[best]) best = lc;
      if (rc < heap_fill && heap_mirror[rc] > heap_mirror[best]) best = rc;
      if (best == slot) break;
      swap_slots(slot, best);
      slot = best;
    end
  endfunction

  function automatic prio_t pop_root();
    prio_t v;
    v = heap_mirror[0];
    heap_fill--;
    heap_mirror[0] = heap_mirror[heap_fill];
    sink_down(0);
    return v;
  endfunction

  function automatic heap_result_t heap_apply(action_t act, logic [POS_W-1:0] pos, prio_t prio);
    heap_result_t r;
    prio_t old;
    int unsigned slot;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        if (heap_fill >= HEAP_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          heap_mirror[heap_fill] = prio;
          heap_fill++;
          bubble_up(heap_fill - 1);
        end
      end
      ACT_EXTRACT: begin
        if (heap_fill == 0) r.status = ST_EMPTY;
        else r.taken = pop_root();
      end
      ACT_CHANGE: begin
        if (pos >= heap_fill) begin
          r.status = ST_BADIDX;
        end else begin
          old = heap_mirror[pos];
          heap_mirror[pos] = prio;
          if (prio > old) bubble_up(pos);
          else sink_down(pos);
        end
      end
      default: begin
        if (pos >= heap_fill) begin
          r.status = ST_BADIDX;
        end else begin
          // bubble to the root regardless of value, then take it
          slot = pos;
          while (slot > 0) begin
            swap_slots(slot, (slot - 1) / 2);
            slot = (slot - 1) / 2;
          end
          r.taken = pop_root();
        end
      end
    endcase
    r.top   = (heap_fill > 0) ? heap_mirror[0] : '0;
    r.count = count_t'(heap_fill);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input action_t act, input logic [POS_W-1:0] pos,
                              input prio_t prio, input logic fixed, input heap_result_t want);
    int unsigned gap;
    heap_result_t predicted;
    gap = 0;
    if (idle_enabled && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.position     <= pos;
    in_ch.priority_req <= prio;
    do @(posedge clk); while (!in_ch.ready);
    predicted = heap_apply(act, pos, prio);
    pending_results.push_back(fixed ? want : predicted);
    op_count[act]++;
    if (predicted.status == ST_FULL) full_hits++;
    if (predicted.status == ST_EMPTY) empty_hits++;
    if (predicted.status == ST_BADIDX) badidx_hits++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d results outstanding", $realtime, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: taken=%0d top=%0d count=%0d status=%0d",
                             out_ch.taken_value, out_ch.top_value, out_ch.entry_count,
                             out_ch.status));
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (out_ch.taken_value !== exp_r.taken || out_ch.top_value !== exp_r.top ||
            out_ch.entry_count !== exp_r.count || out_ch.status !== exp_r.status) begin
          flag_error($sformatf({"result %0d: expected taken=%0d top=%0d count=%0d status=%0d,",
                                " got taken=%0d top=%0d count=%0d status=%0d"},
                               results_checked, exp_r.taken, exp_r.top, exp_r.count,
                               exp_r.status, out_ch.taken_value, out_ch.top_value,
                               out_ch.entry_count, out_ch.status));
        end
      end
    end
  end

  // result side: random stall bursts plus one long hold-off to back the block up
  initial begin : result_sink
    int unsigned burst;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        burst = $urandom_range(1, 18);
        repeat (burst) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : request_source
    int unsigned run_left;
    int unsigned pick;
    bit filling;
    action_t act;
    logic [POS_W-1:0] pos;
    prio_t prio;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_INSERT;
    in_ch.position     = '0;
    in_ch.priority_req = '0;
    idle_enabled       = 1'b1;
    hold_request       = 1'b0;
    heap_fill          = 0;
    cycle_count        = 0;
    mismatch_count     = 0;
    results_checked    = 0;
    full_hits          = 0;
    empty_hits         = 0;
    badidx_hits        = 0;
    foreach (op_count[k]) op_count[k] = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k])
      send_request(directed_rows[k].act, directed_rows[k].pos, directed_rows[k].prio,
                   directed_rows[k].fixed, directed_rows[k].want);

    // alternate fill and drain runs so the heap swings between empty and full
    filling  = 1'b1;
    run_left = $urandom_range(20, 60);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) hold_request = 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_enabled = 1'b0;
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(20, 60);
      end
      run_left--;

      pick = $urandom_range(0, 99);
      if (filling)
        act = (pick < 55) ? ACT_INSERT : (pick < 70) ? ACT_EXTRACT :
              (pick < 88) ? ACT_CHANGE : ACT_REMOVE;
      else
        act = (pick < 25) ? ACT_INSERT : (pick < 55) ? ACT_EXTRACT :
              (pick < 78) ? ACT_CHANGE : ACT_REMOVE;

      if (heap_fill > 0 && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(0, heap_fill - 1));
      else
        pos = POS_W'($urandom_range(0, HEAP_SLOTS - 1));

      case ($urandom_range(0, 3))
        0, 1: prio = $urandom;
        2: prio = int'($urandom_range(0, 16)) - 8;     // narrow range forces ties
        default: begin
          case ($urandom_range(0, 3))
            0: prio = 32'sh8000_0000;
            1: prio = 32'sh7fff_ffff;
            2: prio = 32'sd0;
            default: prio = -32'sd1;
          endcase
        end
      endcase

      send_request(act, pos, prio, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Requests: %0d insert, %0d extract, %0d change, %0d remove; %0d results checked.",
             op_count[ACT_INSERT], op_count[ACT_EXTRACT], op_count[ACT_CHANGE],
             op_count[ACT_REMOVE], results_checked);
    $display("Error paths hit: %0d full inserts, %0d empty extracts, %0d bad positions.",
             full_hits, empty_hits, badidx_hits);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_if.sv
hw/rtl/binary_max_heap_queue.sv
verif/binary_max_heap_queue_tb.sv
